// File: hdl/psas_pkg.sv
// shared types, constants and command/status structs for the pressure autozero scaler
// no dependencies; imported by the interfaces and every module
package psas_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int AVG_FRAC_DEF = 8;

  localparam int PT_W       = 16;  // zero and full points
  localparam int DEF_W      = 10;  // default points
  localparam int CNT_W      = 10;  // calibration sample count
  localparam int OUT_W      = 12;  // tenths of psi
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SCALE_SPAN      = 1000;
  localparam int SCALE_W         = $clog2(SCALE_SPAN);
  localparam int NEAR_ZERO_LIMIT = 200;
  localparam int OUT_MAX         = 4095;

  localparam logic [PT_W-1:0]  STORED_ZERO_RESET   = 16'hFFFF;
  localparam logic [PT_W-1:0]  STORED_FULL_RESET   = 16'hFFFF;
  localparam logic [DEF_W-1:0] DEFAULT_ZERO_RESET  = 10'd90;
  localparam logic [DEF_W-1:0] DEFAULT_FULL_RESET  = 10'd860;
  localparam logic [CNT_W-1:0] CAL_SAMPLES_RESET   = 10'd150;
  localparam logic [OUT_W-1:0] LOW_THRESHOLD_RESET = 12'd100;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_BEGIN  = 2'd1,
    REQ_RECAL  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STORED_ZERO   = 3'd0,
    CFG_STORED_FULL   = 3'd1,
    CFG_DEFAULT_ZERO  = 3'd2,
    CFG_DEFAULT_FULL  = 3'd3,
    CFG_CAL_SAMPLES   = 3'd4,
    CFG_LOW_THRESHOLD = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic commit;
  } psas_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_last;
  } psas_status_t;

endpackage

// File: hdl/psas_if.sv
// channel interfaces: request items, result items and configuration writes
// depends on psas_pkg for field widths
interface psas_item_if import psas_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, req_type, adc_sample, input ready);
  modport sink   (input valid, req_type, adc_sample, output ready);
endinterface

interface psas_result_if import psas_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] pressure_tenths;
  logic             low_warning;
  logic             calibrating;
  logic [PT_W-1:0]  zero_point;
  logic [PT_W-1:0]  full_point;
  logic             cal_done;

  modport source (output valid, pressure_tenths, low_warning, calibrating, zero_point,
                  full_point, cal_done, input ready);
  modport sink   (input valid, pressure_tenths, low_warning, calibrating, zero_point,
                  full_point, cal_done, output ready);
endinterface

interface psas_cfg_if import psas_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/psas_ctrl.sv
// controller state machine: sequences capture, divide and commit of one request
// depends on psas_pkg for state and command/status types
module psas_ctrl import psas_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  output logic         result_valid,
  input  logic         result_ready,
  output psas_cmd_t    cmd,
  input  psas_status_t status
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    item_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.needs_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // result register must be empty or draining
        if (!result_valid || result_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state == ST_EXEC))
    else $error("accepted request did not move to execute");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("commit did not present a result");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && status.div_last) |=> (state == ST_COMMIT))
    else $error("divide did not finish into commit");

  a_short_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && !status.needs_div) |=> (state == ST_COMMIT))
    else $error("request without divide did not go straight to commit");
`endif

endmodule

// File: hdl/psas_datapath.sv
// datapath: configuration registers, calibration state, sample mapping with a
// bit-serial divider, averaging and the result register; depends on psas_pkg
module psas_datapath import psas_pkg::*; #(
  parameter int ADC_BITS      = ADC_BITS_DEF,
  parameter int AVG_FRAC_BITS = AVG_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  psas_cmd_t             cmd,
  output psas_status_t          status,
  input  logic [1:0]            req_type,
  input  logic [ADC_BITS-1:0]   adc_sample,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_W-1:0]      pressure_tenths,
  output logic                  low_warning,
  output logic                  calibrating,
  output logic [PT_W-1:0]       zero_point,
  output logic [PT_W-1:0]       full_point,
  output logic                  cal_done
);

  localparam int AVG_W  = OUT_W + AVG_FRAC_BITS;
  localparam int DIV_W  = ADC_BITS + SCALE_W;
  localparam int STEP_W = $clog2(DIV_W);

  // configuration
  logic [PT_W-1:0]  stored_zero;
  logic [PT_W-1:0]  stored_full;
  logic [DEF_W-1:0] default_zero;
  logic [DEF_W-1:0] default_full;
  logic [CNT_W-1:0] cal_samples;
  logic [OUT_W-1:0] low_threshold;

  // working state
  logic [PT_W-1:0]  zero_reg;
  logic [PT_W-1:0]  full_reg;
  logic [AVG_W-1:0] average_fix;
  logic             cal_active;
  logic [CNT_W-1:0] cal_counter;

  // captured request
  logic [1:0]          req;
  logic [ADC_BITS-1:0] raw;

  // divider
  logic [DIV_W-1:0]  dq;
  logic [PT_W-1:0]   rem;
  logic [PT_W-1:0]   divisor;
  logic [STEP_W-1:0] step;
  logic [PT_W:0]     trial;
  logic              q_bit;
  logic [PT_W-1:0]   rem_next;

  logic [PT_W-1:0]     raw_w;
  logic                below;
  logic [PT_W-1:0]     span;
  logic [ADC_BITS-1:0] diff;
  logic                map_div;
  logic [OUT_W-1:0]    m_direct;
  logic [OUT_W-1:0]    q_sat;
  logic [OUT_W-1:0]    m;
  logic [AVG_W-1:0]    v;
  logic [AVG_W:0]      avg_sum;
  logic [PT_W:0]       twice_def;
  logic [PT_W-1:0]     z_dec;
  logic [PT_W-1:0]     z_inc;
  logic                cal_end;

  logic [PT_W-1:0]  zero_next;
  logic [PT_W-1:0]  full_next;
  logic [AVG_W-1:0] average_fix_next;
  logic             cal_active_next;
  logic [CNT_W-1:0] cal_counter_next;
  logic             done_next;
  logic [OUT_W-1:0] pressure_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_zero   <= STORED_ZERO_RESET;
      stored_full   <= STORED_FULL_RESET;
      default_zero  <= DEFAULT_ZERO_RESET;
      default_full  <= DEFAULT_FULL_RESET;
      cal_samples   <= CAL_SAMPLES_RESET;
      low_threshold <= LOW_THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STORED_ZERO:   stored_zero   <= cfg_data[PT_W-1:0];
        CFG_STORED_FULL:   stored_full   <= cfg_data[PT_W-1:0];
        CFG_DEFAULT_ZERO:  default_zero  <= cfg_data[DEF_W-1:0];
        CFG_DEFAULT_FULL:  default_full  <= cfg_data[DEF_W-1:0];
        CFG_CAL_SAMPLES:   cal_samples   <= cfg_data[CNT_W-1:0];
        CFG_LOW_THRESHOLD: low_threshold <= cfg_data[OUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= req_type;
      raw <= adc_sample;
    end
  end

  // sample mapping
  assign raw_w    = PT_W'(raw);
  assign below    = raw_w < zero_reg;
  assign span     = full_reg - zero_reg;
  assign diff     = ADC_BITS'(raw_w - zero_reg);
  assign map_div  = (req == REQ_SAMPLE) && !cal_active && !below && (full_reg > zero_reg);
  // equal points give full scale, reversed points or a low sample give zero
  assign m_direct = (!below && full_reg == zero_reg) ? OUT_W'(OUT_MAX) : '0;
  assign q_sat    = (|dq[DIV_W-1:OUT_W]) ? OUT_W'(OUT_MAX) : dq[OUT_W-1:0];
  assign m        = map_div ? q_sat : m_direct;

  assign status.needs_div = map_div;
  assign status.div_last  = (step == STEP_W'(DIV_W - 1));

  // restoring divide, one quotient bit per cycle
  assign trial    = {rem, dq[DIV_W-1]};
  assign q_bit    = trial >= {1'b0, divisor};
  assign rem_next = q_bit ? PT_W'(trial - {1'b0, divisor}) : trial[PT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq      <= DIV_W'(diff) * DIV_W'(SCALE_SPAN);
      rem     <= '0;
      divisor <= span;
      step    <= '0;
    end else if (cmd.div_step) begin
      dq   <= {dq[DIV_W-2:0], q_bit};
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
  end

  // auto-zero nudge: step down first, then up against the updated point
  assign z_dec   = (raw_w < zero_reg && raw_w != '0) ? zero_reg - PT_W'(1) : zero_reg;
  assign z_inc   = (raw_w > z_dec && raw_w < PT_W'(NEAR_ZERO_LIMIT)) ? z_dec + PT_W'(1)
                                                                     : z_dec;
  assign cal_end = ({1'b0, cal_counter} + (CNT_W+1)'(1)) >= {1'b0, cal_samples};

  assign twice_def = {{(PT_W-DEF_W){1'b0}}, default_zero, 1'b0};
  assign v         = AVG_W'(m) << AVG_FRAC_BITS;
  assign avg_sum   = {1'b0, average_fix} + {1'b0, v};

  always_comb begin
    zero_next        = zero_reg;
    full_next        = full_reg;
    average_fix_next = average_fix;
    cal_active_next  = cal_active;
    cal_counter_next = cal_counter;
    done_next        = 1'b0;
    unique case (req)
      REQ_BEGIN: begin
        if ({1'b0, stored_zero} > twice_def) begin
          zero_next       = PT_W'(default_zero);
          full_next       = PT_W'(default_full);
          cal_active_next = 1'b1;
        end else begin
          zero_next       = stored_zero;
          full_next       = stored_full;
          cal_active_next = 1'b0;
        end
        cal_counter_next = '0;
      end
      REQ_RECAL: begin
        zero_next        = PT_W'(default_zero);
        full_next        = PT_W'(default_full);
        cal_active_next  = 1'b1;
        cal_counter_next = '0;
      end
      REQ_SAMPLE: begin
        if (cal_active) begin
          zero_next = z_inc;
          if (cal_end) begin
            // shift full point by the zero change
            full_next        = full_reg - PT_W'(default_zero) + z_inc;
            cal_active_next  = 1'b0;
            cal_counter_next = '0;
            done_next        = 1'b1;
          end else begin
            cal_counter_next = cal_counter + CNT_W'(1);
          end
        end else if (average_fix != '0) begin
          average_fix_next = avg_sum[AVG_W:1];
        end else begin
          average_fix_next = v;
        end
      end
      default: begin
      end
    endcase
  end

  assign pressure_next = average_fix_next[AVG_W-1 -: OUT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_reg    <= PT_W'(DEFAULT_ZERO_RESET);
      full_reg    <= PT_W'(DEFAULT_FULL_RESET);
      average_fix <= '0;
      cal_active  <= 1'b0;
      cal_counter <= '0;
    end else if (cmd.commit) begin
      zero_reg    <= zero_next;
      full_reg    <= full_next;
      average_fix <= average_fix_next;
      cal_active  <= cal_active_next;
      cal_counter <= cal_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pressure_tenths <= pressure_next;
      low_warning     <= pressure_next < low_threshold;
      calibrating     <= cal_active_next;
      zero_point      <= zero_next;
      full_point      <= full_next;
      cal_done        <= done_next;
    end
  end

endmodule

// File: hdl/pressure_sensor_autozero_scaler_core.sv
// top level of the pressure autozero scaler: controller plus datapath
// depends on psas_pkg, psas_if, psas_ctrl and psas_datapath
//
// One request is handled at a time and each gives exactly one result. A begin,
// recalibrate, unused-code or calibration-sample request goes from capture
// through execute to commit without a divide. A sample in normal mode whose reading is
// at or above the zero point with the full point above it is scaled by a
// restoring divider that produces one quotient bit per cycle between execute
// and commit. The result sits in an
// output register, so a new request is taken while the previous result still
// waits. Configuration writes are always ready and should only be issued
// while no request is in flight. There is no start-up clearing pass.
module pressure_sensor_autozero_scaler_core import psas_pkg::*; #(
  parameter int ADC_BITS      = ADC_BITS_DEF,
  parameter int AVG_FRAC_BITS = AVG_FRAC_DEF
) (
  input logic           clk,
  input logic           rst,
  psas_item_if.sink     item,
  psas_result_if.source result,
  psas_cfg_if.sink      cfg
);

  psas_cmd_t    cmd;
  psas_status_t status;

  assign cfg.ready = 1'b1;

  psas_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .status       (status)
  );

  psas_datapath #(
    .ADC_BITS      (ADC_BITS),
    .AVG_FRAC_BITS (AVG_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (item.req_type),
    .adc_sample      (item.adc_sample),
    .cfg_write       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .pressure_tenths (result.pressure_tenths),
    .low_warning     (result.low_warning),
    .calibrating     (result.calibrating),
    .zero_point      (result.zero_point),
    .full_point      (result.full_point),
    .cal_done        (result.cal_done)
  );

endmodule

// File: dv/tb.sv
// self-checking bench for pressure_sensor_autozero_scaler_core: directed and random requests
// depends on psas_pkg and the channel interfaces in psas_if; predicts every result in a scoreboard
module tb import psas_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AVG_W = OUT_W + AVG_FRAC_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] pressure_tenths;
    logic             low_warning;
    logic             calibrating;
    logic [PT_W-1:0]  zero_point;
    logic [PT_W-1:0]  full_point;
    logic             cal_done;
  } gauge_reading_t;

  class pressure_scoreboard;
    logic [PT_W-1:0]  stored_zero, stored_full;
    logic [DEF_W-1:0] default_zero, default_full;
    logic [CNT_W-1:0] cal_samples;
    logic [OUT_W-1:0] low_threshold;
    logic [PT_W-1:0]  zero_pt, full_pt;
    logic [AVG_W-1:0] avg_fix;
    logic             cal_active;
    logic [CNT_W-1:0] cal_count;
    gauge_reading_t   expected_readings[$];
    int               errors;

    function new();
      stored_zero   = STORED_ZERO_RESET;
      stored_full   = STORED_FULL_RESET;
      default_zero  = DEFAULT_ZERO_RESET;
      default_full  = DEFAULT_FULL_RESET;
      cal_samples   = CAL_SAMPLES_RESET;
      low_threshold = LOW_THRESHOLD_RESET;
      zero_pt       = PT_W'(DEFAULT_ZERO_RESET);
      full_pt       = PT_W'(DEFAULT_FULL_RESET);
      avg_fix       = '0;
      cal_active    = 1'b0;
      cal_count     = '0;
      errors        = 0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STORED_ZERO:   stored_zero   = value;
        CFG_STORED_FULL:   stored_full   = value;
        CFG_DEFAULT_ZERO:  default_zero  = value[DEF_W-1:0];
        CFG_DEFAULT_FULL:  default_full  = value[DEF_W-1:0];
        CFG_CAL_SAMPLES:   cal_samples   = value[CNT_W-1:0];
        CFG_LOW_THRESHOLD: low_threshold = value[OUT_W-1:0];
        default: ;
      endcase
    endfunction

    function void start_pass();
      zero_pt    = PT_W'(default_zero);
      full_pt    = PT_W'(default_full);
      cal_active = 1'b1;
      cal_count  = '0;
    endfunction

    // linear map between zero and full points, truncated and saturated
    function logic [OUT_W-1:0] scale_reading(logic [ADC_BITS_DEF-1:0] raw);
      int unsigned q;
      if (raw < zero_pt) return '0;
      if (full_pt == zero_pt) return OUT_W'(OUT_MAX);
      if (full_pt < zero_pt) return '0;
      q = ((32'(raw) - 32'(zero_pt)) * SCALE_SPAN) / (32'(full_pt) - 32'(zero_pt));
      return (q > OUT_MAX) ? OUT_W'(OUT_MAX) : q[OUT_W-1:0];
    endfunction

    function void note_request(logic [1:0] kind, logic [ADC_BITS_DEF-1:0] raw);
      logic [AVG_W-1:0] scaled;
      logic [AVG_W:0]   sum;
      gauge_reading_t   exp_r;
      logic             done;
      done = 1'b0;
      case (kind)
        REQ_BEGIN: begin
          if ({1'b0, stored_zero} > {6'b0, default_zero, 1'b0}) begin
            start_pass();
          end else begin
            zero_pt    = stored_zero;
            full_pt    = stored_full;
            cal_active = 1'b0;
            cal_count  = '0;
          end
        end
        REQ_RECAL: start_pass();
        REQ_SAMPLE: begin
          if (cal_active) begin
            if (raw < zero_pt && raw > 0) zero_pt = zero_pt - 1'b1;
            if (raw > zero_pt && raw < NEAR_ZERO_LIMIT) zero_pt = zero_pt + 1'b1;
            if (32'(cal_count) + 1 >= 32'(cal_samples)) begin
              // shift the full point by however far the zero moved
              full_pt    = full_pt - (PT_W'(default_zero) - zero_pt);
              cal_active = 1'b0;
              cal_count  = '0;
              done       = 1'b1;
            end else begin
              cal_count = cal_count + 1'b1;
            end
          end else begin
            scaled = AVG_W'(scale_reading(raw)) << AVG_FRAC_DEF;
            if (avg_fix != '0) begin
              sum     = avg_fix + scaled;
              avg_fix = sum[AVG_W:1];
            end else begin
              avg_fix = scaled;
            end
          end
        end
        default: ;
      endcase
      exp_r.pressure_tenths = avg_fix[AVG_W-1:AVG_FRAC_DEF];
      exp_r.low_warning     = avg_fix < {low_threshold, {AVG_FRAC_DEF{1'b0}}};
      exp_r.calibrating     = cal_active;
      exp_r.zero_point      = zero_pt;
      exp_r.full_point      = full_pt;
      exp_r.cal_done        = done;
      expected_readings.push_back(exp_r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_reading(gauge_reading_t got);
      gauge_reading_t want;
      if (expected_readings.size() == 0) begin
        $error("result with no request waiting");
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      compare_field("pressure_tenths", 32'(want.pressure_tenths), 32'(got.pressure_tenths));
      compare_field("low_warning", 32'(want.low_warning), 32'(got.low_warning));
      compare_field("calibrating", 32'(want.calibrating), 32'(got.calibrating));
      compare_field("zero_point", 32'(want.zero_point), 32'(got.zero_point));
      compare_field("full_point", 32'(want.full_point), 32'(got.full_point));
      compare_field("cal_done", 32'(want.cal_done), 32'(got.cal_done));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  psas_item_if   item_ch();
  psas_result_if result_ch();
  psas_cfg_if    cfg_ch();

  pressure_sensor_autozero_scaler_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  pressure_scoreboard sb = new();

  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  int unsigned set_sz, set_sf, set_dz, set_df, set_cs, set_lt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side back-pressure in bursts
  initial begin
    forever begin
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    gauge_reading_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_register(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
      if (item_ch.valid && item_ch.ready) sb.note_request(item_ch.req_type, item_ch.adc_sample);
      if (result_ch.valid && result_ch.ready) begin
        got.pressure_tenths = result_ch.pressure_tenths;
        got.low_warning     = result_ch.low_warning;
        got.calibrating     = result_ch.calibrating;
        got.zero_point      = result_ch.zero_point;
        got.full_point      = result_ch.full_point;
        got.cal_done        = result_ch.cal_done;
        sb.check_reading(got);
      end
    end
  end

  task automatic send_request(logic [1:0] kind, logic [ADC_BITS_DEF-1:0] raw);
    if (source_gaps && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.req_type   <= kind;
    item_ch.adc_sample <= raw;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic load_settings();
    cfg_idx_t         order[6];
    logic [CFG_DATA_W-1:0] values[6];
    order  = '{CFG_STORED_ZERO, CFG_STORED_FULL, CFG_DEFAULT_ZERO,
               CFG_DEFAULT_FULL, CFG_CAL_SAMPLES, CFG_LOW_THRESHOLD};
    values = '{CFG_DATA_W'(set_sz), CFG_DATA_W'(set_sf), CFG_DATA_W'(set_dz),
               CFG_DATA_W'(set_df), CFG_DATA_W'(set_cs), CFG_DATA_W'(set_lt)};
    foreach (order[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= order[i];
      cfg_ch.data  <= values[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // drain every outstanding result, then idle before the next block
  task automatic settle_block();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [ADC_BITS_DEF-1:0] near_zero_reading();
    if ($urandom_range(0, 9) == 0) return ADC_BITS_DEF'($urandom_range(0, 1023));
    return ADC_BITS_DEF'($urandom_range(0, 255));
  endfunction

  function automatic logic [ADC_BITS_DEF-1:0] any_reading();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ADC_BITS_DEF'($urandom_range(0, 255));
      default: return ADC_BITS_DEF'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    int         sent;
    int         pass_len;
    logic [1:0] kind;
    bit         in_pass;

    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.req_type   <= REQ_SAMPLE;
    item_ch.adc_sample <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_STORED_ZERO;
    cfg_ch.data        <= '0;
    set_sz = 32'(STORED_ZERO_RESET);
    set_sf = 32'(STORED_FULL_RESET);
    set_dz = 32'(DEFAULT_ZERO_RESET);
    set_df = 32'(DEFAULT_FULL_RESET);
    set_cs = 32'(CAL_SAMPLES_RESET);
    set_lt = 32'(LOW_THRESHOLD_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: warning straight after reset, extremes and samples at the zero
    send_request(REQ_UNUSED, '1);
    send_request(REQ_SAMPLE, '1);
    send_request(REQ_SAMPLE, '0);
    send_request(REQ_SAMPLE, 10'd90);
    send_request(REQ_SAMPLE, 10'd89);
    settle_block();

    // zero-length pass ends on its first sample
    set_cs = 0;
    load_settings();
    send_request(REQ_BEGIN, '0);
    send_request(REQ_SAMPLE, 10'd1);
    send_request(REQ_UNUSED, 10'd512);
    settle_block();

    // nudges both ways, begin restarting a pass mid-way
    set_cs = 3;
    load_settings();
    send_request(REQ_RECAL, '0);
    send_request(REQ_SAMPLE, 10'd0);
    send_request(REQ_SAMPLE, 10'd150);
    send_request(REQ_BEGIN, 10'd7);
    send_request(REQ_SAMPLE, 10'd199);
    send_request(REQ_SAMPLE, 10'd50);
    send_request(REQ_SAMPLE, 10'd120);
    settle_block();

    // stored points with zero span
    set_sz = 100;
    set_sf = 100;
    set_lt = 4095;
    load_settings();
    send_request(REQ_BEGIN, '0);
    send_request(REQ_SAMPLE, 10'd500);
    send_request(REQ_SAMPLE, 10'd99);
    settle_block();

    // negative span
    set_sf = 50;
    load_settings();
    send_request(REQ_BEGIN, '0);
    send_request(REQ_SAMPLE, 10'd700);
    settle_block();

    // one-count span saturates, begin stopping a forced pass
    set_sf = 101;
    set_lt = 0;
    load_settings();
    send_request(REQ_BEGIN, '0);
    send_request(REQ_SAMPLE, '1);
    send_request(REQ_RECAL, '0);
    send_request(REQ_BEGIN, '0);
    settle_block();

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        set_sz = 32'hFFFF; set_sf = 32'hFFFF; set_dz = 1023;
        set_df = 1023;     set_cs = 1023;     set_lt = 4095;
      end else if (phase == 1) begin
        set_sz = 0; set_sf = 0; set_dz = 0; set_df = 0; set_cs = 0; set_lt = 0;
      end else begin
        set_dz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(40, 200);
        if ($urandom_range(0, 9) < 7) begin
          set_df = set_dz + $urandom_range(200, 800);
          if (set_df > 1023) set_df = 1023;
        end else begin
          set_df = $urandom_range(0, 1023);
        end
        if ($urandom_range(0, 1) == 0) set_sz = $urandom_range(0, 2 * set_dz);
        else if ($urandom_range(0, 1) == 0) set_sz = 32'hFFFF;
        else set_sz = $urandom_range(0, 65535);
        if ($urandom_range(0, 9) < 8) set_sf = (set_sz + $urandom_range(1, 1100)) & 16'hFFFF;
        else set_sf = $urandom_range(0, 65535);
        case ($urandom_range(0, 5))
          0: set_cs = 0;
          1: set_cs = $urandom_range(17, 60);
          default: set_cs = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 5))
          0: set_lt = 0;
          1: set_lt = 4095;
          default: set_lt = $urandom_range(0, 1200);
        endcase
      end
      load_settings();

      // quiet tail: no idling on either side in the last phase
      source_gaps = (phase == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_stalls = (phase == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);

      sent = 0;
      while (sent < 80) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: kind = REQ_BEGIN;
          4, 5, 6, 7: kind = REQ_RECAL;
          default:    kind = REQ_SAMPLE;
        endcase
        if (kind != REQ_SAMPLE) begin
          send_request(kind, ADC_BITS_DEF'($urandom_range(0, 1023)));
          sent++;
        end
        in_pass = (kind == REQ_RECAL) || (kind == REQ_BEGIN && set_sz > 2 * set_dz);
        if (in_pass) begin
          pass_len = (set_cs == 0) ? 1 : set_cs;
          // long passes are cut short by the per-phase request budget
          for (int i = 0; i < pass_len && sent < 80; i++) begin
            // occasional stray request of any kind, which may interrupt the pass
            if ($urandom_range(0, 19) == 0)
              send_request(2'($urandom_range(0, 3)), ADC_BITS_DEF'($urandom_range(0, 1023)));
            else
              send_request(REQ_SAMPLE, near_zero_reading());
            sent++;
          end
        end
        repeat ($urandom_range(2, 12)) begin
          if ($urandom_range(0, 24) == 0) send_request(REQ_UNUSED, any_reading());
          else send_request(REQ_SAMPLE, any_reading());
          sent++;
        end
      end
      settle_block();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: pressure_sensor_autozero_scaler_core.f
hdl/psas_pkg.sv
hdl/psas_if.sv
hdl/psas_ctrl.sv
hdl/psas_datapath.sv
hdl/pressure_sensor_autozero_scaler_core.sv
dv/tb.sv
